[rtl/core/bsc_pkg.sv]
// Shared constants, types and codes for the banker's safety check block.
`timescale 1ns / 1ps

package bsc_pkg;

  // Sizing
  localparam int MAX_PROCS = 8;
  localparam int NUM_RES   = 3;
  localparam int RES_SLOTS = 3;                       // resource fields on the ports
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int VAL_W     = 8;
  localparam int WORK_W    = 12;
  localparam int PIDX_W    = 3;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 2;

  typedef logic [WORK_W-1:0] work_t;
  typedef logic [VAL_W-1:0]  val_t;

  localparam work_t WORK_MAX = '1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_SAFE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNSAFE  = 2'd1;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AVAIL_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVAIL_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AVAIL_C = 2'd2;

  // Reset values of the available vector
  localparam val_t AVAIL_RST_A = 8'd3;
  localparam val_t AVAIL_RST_B = 8'd3;
  localparam val_t AVAIL_RST_C = 8'd2;

  // One stored process record
  typedef struct packed {
    val_t [RES_SLOTS-1:0] alloc;
    val_t [RES_SLOTS-1:0] need;
  } rec_t;

  // Fit test and updated work vector for one record
  typedef struct packed {
    logic                  ok;
    work_t [RES_SLOTS-1:0] sum;
  } fit_res_t;

  typedef enum logic [3:0] {
    S_LOAD  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

endpackage

[rtl/core/bsc_fit.sv]
// Need-versus-work compare and saturating work update for one record.
`timescale 1ns / 1ps

module bsc_fit import bsc_pkg::*; (
  input  work_t [RES_SLOTS-1:0] work,
  input  rec_t                  rec,
  output fit_res_t              res
);

  always_comb begin
    logic [WORK_W:0] s;
    s       = '0;
    res.ok  = 1'b1;
    res.sum = work;
    // resources above NUM_RES pass through untouched
    for (int r = 0; r < NUM_RES; r++) begin
      if (WORK_W'(rec.need[r]) > work[r]) res.ok = 1'b0;
      s = {1'b0, work[r]} + (WORK_W + 1)'(rec.alloc[r]);
      res.sum[r] = s[WORK_W] ? WORK_MAX : s[WORK_W-1:0];
    end
  end

endmodule

[rtl/core/bankers_safety_check_top.sv]
// Top level: record store, safety check sequencer and result output register.
// A non-final record is written to the record memory when accepted, unless that is full.
// After the final record of a valid run the check makes passes over the records, one
//   record read per cycle from the record memory, until a pass makes no progress or all are
//   finished (at most records passes). Results then leave at one per cycle from the
//   output register unless out_ready holds them; the scan is bound by the single read port.
// Reset (rst_n low, synchronous) clears run state and sets avail to 3, 3, 2.
`timescale 1ns / 1ps

module bankers_safety_check_top import bsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_wdata,
  // record input
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [VAL_W-1:0]     in_alloc_a,
  input  logic [VAL_W-1:0]     in_alloc_b,
  input  logic [VAL_W-1:0]     in_alloc_c,
  input  logic [VAL_W-1:0]     in_claim_a,
  input  logic [VAL_W-1:0]     in_claim_b,
  input  logic [VAL_W-1:0]     in_claim_c,
  input  logic                 in_final_record,
  // results
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIDX_W-1:0]    out_process_index,
  output logic [STAT_W-1:0]    out_status,
  output logic                 out_end_of_run
);

  state_t                state_r, state_nxt;
  val_t [RES_SLOTS-1:0]  avail_r;
  logic [CNT_W-1:0]      rec_cnt_r, rec_cnt_nxt;
  logic                  inv_r, inv_nxt;
  logic [MAX_PROCS-1:0]  fin_r, fin_nxt;
  logic [CNT_W-1:0]      done_r, done_nxt;
  work_t [RES_SLOTS-1:0] work_r, work_nxt;
  logic                  prog_r, prog_nxt;
  logic [IDX_W-1:0]      scan_p_r, scan_p_nxt;
  logic                  s1_v_r, s1_v_nxt;
  logic [IDX_W-1:0]      s1_p_r, s1_p_nxt;
  logic [IDX_W-1:0]      emit_k_r, emit_k_nxt;
  logic [STAT_W-1:0]     emit_st_r, emit_st_nxt;
  logic                  out_valid_r;
  logic [PIDX_W-1:0]     out_idx_r;
  logic [STAT_W-1:0]     out_st_r, out_st_nxt;
  logic                  out_end_r, out_end_nxt;
  logic                  out_load;

  // record memory and its read data
  rec_t                  rec_mem [MAX_PROCS];
  rec_t                  rd_data_r;
  rec_t                  mem_wdata;
  logic                  mem_we;

  // safe order store
  logic [IDX_W-1:0]      order_r [MAX_PROCS];
  logic                  ord_we;

  val_t [RES_SLOTS-1:0]  in_alloc, in_claim;
  logic                  in_acc, full, rec_bad, inv_now, fire, last_issue, last_emit;
  fit_res_t              fit;

  assign in_ready = (state_r == S_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign full     = (rec_cnt_r >= CNT_W'(MAX_PROCS));

  assign in_alloc = {in_alloc_c, in_alloc_b, in_alloc_a};
  assign in_claim = {in_claim_c, in_claim_b, in_claim_a};

  // record build: need = claim - alloc, zero when allocation exceeds claim
  always_comb begin
    rec_bad   = 1'b0;
    mem_wdata = '0;
    for (int r = 0; r < RES_SLOTS; r++) begin
      mem_wdata.alloc[r] = in_alloc[r];
      mem_wdata.need[r]  = (in_alloc[r] > in_claim[r]) ? '0 : (in_claim[r] - in_alloc[r]);
    end
    for (int r = 0; r < NUM_RES; r++) begin
      if (in_alloc[r] > in_claim[r]) rec_bad = 1'b1;
    end
  end

  // fit test on the record read last cycle
  bsc_fit u_fit (
    .work (work_r),
    .rec  (rd_data_r),
    .res  (fit)
  );

  assign fire       = s1_v_r && !fin_r[s1_p_r] && fit.ok;
  assign last_issue = (CNT_W'(scan_p_r) + CNT_W'(1)) == rec_cnt_r;
  assign last_emit  = (CNT_W'(emit_k_r) + CNT_W'(1)) == done_r;

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    rec_cnt_nxt = rec_cnt_r;
    inv_nxt     = inv_r;
    fin_nxt     = fin_r;
    done_nxt    = done_r;
    work_nxt    = work_r;
    prog_nxt    = prog_r;
    scan_p_nxt  = scan_p_r;
    s1_v_nxt    = 1'b0;
    s1_p_nxt    = s1_p_r;
    emit_k_nxt  = emit_k_r;
    emit_st_nxt = emit_st_r;
    out_load    = 1'b0;
    out_st_nxt  = emit_st_r;
    out_end_nxt = 1'b1;
    mem_we      = 1'b0;
    ord_we      = 1'b0;
    inv_now     = inv_r || full || rec_bad;

    // evaluate the record in stage 1
    if (fire) begin
      work_nxt          = fit.sum;
      fin_nxt[s1_p_r]   = 1'b1;
      done_nxt          = done_r + CNT_W'(1);
      prog_nxt          = 1'b1;
      ord_we            = 1'b1;
    end

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (!full) begin
            mem_we      = 1'b1;
            rec_cnt_nxt = rec_cnt_r + CNT_W'(1);
          end
          inv_nxt = inv_now;
          if (in_final_record) begin
            inv_nxt    = 1'b0;
            fin_nxt    = '0;
            done_nxt   = '0;
            prog_nxt   = 1'b0;
            scan_p_nxt = '0;
            emit_k_nxt = '0;
            for (int r = 0; r < RES_SLOTS; r++) work_nxt[r] = WORK_W'(avail_r[r]);
            if (inv_now) begin
              state_nxt   = S_EMIT;
              emit_st_nxt = ST_INVALID;
            end else begin
              state_nxt = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        s1_v_nxt = 1'b1;
        s1_p_nxt = scan_p_r;
        if (last_issue) state_nxt = S_DRAIN;
        else scan_p_nxt = scan_p_r + IDX_W'(1);
      end
      S_DRAIN: begin
        // last record of the pass is evaluated here
        emit_k_nxt = '0;
        if (done_nxt == rec_cnt_r) begin
          state_nxt   = S_EMIT;
          emit_st_nxt = ST_SAFE;
        end else if (prog_nxt) begin
          state_nxt  = S_SCAN;
          scan_p_nxt = '0;
          prog_nxt   = 1'b0;
        end else begin
          state_nxt   = S_EMIT;
          emit_st_nxt = ST_UNSAFE;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          if (emit_st_r == ST_SAFE) begin
            out_end_nxt = last_emit;
            if (last_emit) begin
              state_nxt   = S_LOAD;
              rec_cnt_nxt = '0;
            end else begin
              emit_k_nxt = emit_k_r + IDX_W'(1);
            end
          end else begin
            state_nxt   = S_LOAD;
            rec_cnt_nxt = '0;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      avail_r     <= {AVAIL_RST_C, AVAIL_RST_B, AVAIL_RST_A};
      rec_cnt_r   <= '0;
      inv_r       <= 1'b0;
      fin_r       <= '0;
      done_r      <= '0;
      work_r      <= '0;
      prog_r      <= 1'b0;
      scan_p_r    <= '0;
      s1_v_r      <= 1'b0;
      s1_p_r      <= '0;
      emit_k_r    <= '0;
      emit_st_r   <= ST_SAFE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rec_cnt_r   <= rec_cnt_nxt;
      inv_r       <= inv_nxt;
      fin_r       <= fin_nxt;
      done_r      <= done_nxt;
      work_r      <= work_nxt;
      prog_r      <= prog_nxt;
      scan_p_r    <= scan_p_nxt;
      s1_v_r      <= s1_v_nxt;
      s1_p_r      <= s1_p_nxt;
      emit_k_r    <= emit_k_nxt;
      emit_st_r   <= emit_st_nxt;
      out_valid_r <= out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
      if (cfg_we) begin
        case (cfg_index)
          CFG_AVAIL_A: avail_r[0] <= cfg_wdata;
          CFG_AVAIL_B: avail_r[1] <= cfg_wdata;
          CFG_AVAIL_C: avail_r[2] <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // record memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) rec_mem[rec_cnt_r[IDX_W-1:0]] <= mem_wdata;
    rd_data_r <= rec_mem[scan_p_r];
  end

  // safe order store; its read lands directly in the output register
  always_ff @(posedge clk) begin
    if (ord_we) order_r[done_r[IDX_W-1:0]] <= s1_p_r;
    if (out_load) begin
      out_idx_r <= (emit_st_r == ST_SAFE) ? PIDX_W'(order_r[emit_k_r]) : '0;
      out_st_r  <= out_st_nxt;
      out_end_r <= out_end_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_process_index = out_idx_r;
  assign out_status        = out_st_r;
  assign out_end_of_run    = out_end_r;

`ifndef SYNTHESIS
  // finished count never passes the record count while a check is live
  a_done_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> (done_r <= rec_cnt_r))
    else $error("finished count exceeds record count");

  // finished mask and finished count agree during the check
  a_fin_matches_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_DRAIN) |-> ($countones(fin_r) == done_r))
    else $error("finished mask out of step with finished count");

  // a safe run finishes every record
  a_safe_all_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && emit_st_r == ST_SAFE) |-> (done_r == rec_cnt_r))
    else $error("safe result with unfinished records");

  // work only grows while records are evaluated
  a_work_grows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |=> (work_r[0] >= $past(work_r[0]) && work_r[1] >= $past(work_r[1])
                && work_r[2] >= $past(work_r[2])))
    else $error("work vector decreased during check");
`endif

endmodule
